### rtl/core/yhra_pkg.sv
package yhra_pkg;

  localparam int PIX_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // divider pipeline depth: one quotient bit per stage
  localparam int S_DIV_STAGES = 30;
  localparam int H_DIV_STAGES = 10;

  // register stages from accepted transaction to result strobe
  localparam int LATENCY = 15 + S_DIV_STAGES;

  // reciprocal of 75 for the t / 75 step, exact for |t| < 2**30
  localparam logic [29:0] RECIP_75    = 30'd916259690;
  localparam int          RECIP_SHIFT = 36;

  // ycbcr to rgb
  localparam logic signed [14:0] K_R_CR = 15'sd11485;
  localparam logic signed [14:0] K_G_CB = 15'sd2818;
  localparam logic signed [14:0] K_G_CR = 15'sd5849;
  localparam logic signed [14:0] K_B_CB = 15'sd14516;

  // rgb to ycbcr
  localparam logic signed [14:0] K_Y_R  = 15'sd4898;
  localparam logic signed [14:0] K_Y_G  = 15'sd9617;
  localparam logic signed [14:0] K_Y_B  = 15'sd1867;
  localparam logic signed [14:0] K_CB_R = -15'sd2768;
  localparam logic signed [14:0] K_CB_G = -15'sd5423;
  localparam logic signed [14:0] K_CB_B = 15'sd8192;
  localparam logic signed [14:0] K_CR_R = 15'sd8192;
  localparam logic signed [14:0] K_CR_G = -15'sd6864;
  localparam logic signed [14:0] K_CR_B = -15'sd1327;

  localparam logic signed [16:0] LUMA_MAX  = 17'sh2000;
  localparam logic signed [16:0] FADE_TOP  = 17'sh3000;
  localparam logic signed [16:0] FADE_LOW  = 17'sh0400;

  typedef enum logic [2:0] {
    CFG_HUE_SHIFT   = 3'd0,
    CFG_LUMA_GAIN   = 3'd1,
    CFG_BRIGHTNESS  = 3'd2,
    CFG_CHROMA_GAIN = 3'd3,
    CFG_CLAMP_MODE  = 3'd4
  } cfg_idx_t;

endpackage

### rtl/core/ycbcr_hue_rotate_adjust.sv
// channel  | ports                                        | handshake
// input    | start, busy, in_y_in, in_cb_in, in_cr_in     | taken when start & !busy
// result   | out_valid, out_y_out, out_cb_out, out_cr_out | one-cycle strobe, no back-pressure
// config   | cfg_we, cfg_idx, cfg_wdata                   | written when cfg_we
//
// one transaction per clock; busy stays low
// result strobe once the transaction has passed 15 arithmetic stages plus
//   30 stages of the saturation divider, one quotient bit per stage
// rst_n is synchronous: clears the stage valid bits and loads register defaults
// the receiver cannot stall, so nothing is held back in the pipeline
module ycbcr_hue_rotate_adjust
  import yhra_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [PIX_W-1:0]      in_y_in,
  input  logic signed [PIX_W-1:0]      in_cb_in,
  input  logic signed [PIX_W-1:0]      in_cr_in,
  output logic                         out_valid,
  output logic signed [PIX_W-1:0]      out_y_out,
  output logic signed [PIX_W-1:0]      out_cb_out,
  output logic signed [PIX_W-1:0]      out_cr_out,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_idx,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

  typedef struct packed {
    logic [27:0]        hrem;
    logic [9:0]         hq;
    logic [17:0]        hdiv;
    logic               hneg;
    logic [11:0]        hbase;
    logic [17:0]        srem;
    logic [29:0]        sq;
    logic [29:0]        snum;
    logic [17:0]        sdiv;
    logic               sneg;
    logic signed [17:0] v;
  } div_stage_t;

  typedef enum logic [2:0] {
    SEC_RY, SEC_YG, SEC_GC, SEC_CB, SEC_BM, SEC_MR
  } hue_sector_t;

  typedef enum logic [1:0] {
    CLP_NONE, CLP_LOW, CLP_HIGH
  } clamp_sel_t;

  logic signed [12:0] hue_shift_r;
  logic [12:0]        luma_gain_r;
  logic signed [13:0] bright_r;
  logic [12:0]        chroma_gain_r;
  logic               clamp_r;

  logic [LATENCY-1:0] vld_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_shift_r   <= '0;
      luma_gain_r   <= 13'd256;
      bright_r      <= '0;
      chroma_gain_r <= 13'd256;
      clamp_r       <= 1'b0;
      vld_r         <= '0;
    end else begin
      vld_r <= {vld_r[LATENCY-2:0], start & ~busy};
      if (cfg_we) begin
        case (cfg_idx)
          CFG_HUE_SHIFT:   hue_shift_r   <= cfg_wdata[12:0];
          CFG_LUMA_GAIN:   luma_gain_r   <= cfg_wdata[12:0];
          CFG_BRIGHTNESS:  bright_r      <= cfg_wdata[13:0];
          CFG_CHROMA_GAIN: chroma_gain_r <= cfg_wdata[12:0];
          CFG_CLAMP_MODE:  clamp_r       <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // stage 1: color matrix products
  logic signed [15:0] p1_y_r;
  logic signed [30:0] p1_rcr_r, p1_gcb_r, p1_gcr_r, p1_bcb_r;

  always_ff @(posedge clk) begin
    p1_y_r   <= in_y_in;
    p1_rcr_r <= in_cr_in * K_R_CR;
    p1_gcb_r <= in_cb_in * K_G_CB;
    p1_gcr_r <= in_cr_in * K_G_CR;
    p1_bcb_r <= in_cb_in * K_B_CB;
  end

  // stage 2: rgb
  logic signed [17:0] p2_r_r, p2_g_r, p2_b_r;
  logic signed [31:0] gsum;
  logic signed [30:0] rsh, bsh;
  logic signed [31:0] gsh;

  always_comb begin
    gsum = 32'(p1_gcb_r) + 32'(p1_gcr_r);
    rsh  = p1_rcr_r >>> 13;
    bsh  = p1_bcb_r >>> 13;
    gsh  = gsum >>> 13;
  end

  always_ff @(posedge clk) begin
    p2_r_r <= 18'(p1_y_r) + 18'(rsh);
    p2_g_r <= 18'(p1_y_r) - 18'(gsh);
    p2_b_r <= 18'(p1_y_r) + 18'(bsh);
  end

  // stage 3: max, min, divider operands
  div_stage_t         dv_r   [0:S_DIV_STAGES];
  div_stage_t         dv_nxt [0:S_DIV_STAGES];
  logic signed [17:0] mx, mn;
  logic signed [18:0] df_s, hx;
  logic [17:0]        df, hxmag;

  always_comb begin
    mx = (p2_r_r > p2_g_r) ? p2_r_r : p2_g_r;
    mx = (mx > p2_b_r) ? mx : p2_b_r;
    mn = (p2_r_r < p2_g_r) ? p2_r_r : p2_g_r;
    mn = (mn < p2_b_r) ? mn : p2_b_r;
    df_s = 19'(mx) - 19'(mn);
    df   = df_s[17:0];
    dv_nxt[0] = '0;
    if (mx == p2_r_r) begin
      hx = 19'(p2_g_r) - 19'(p2_b_r);
      dv_nxt[0].hbase = 12'd0;
    end else if (mx == p2_g_r) begin
      hx = 19'(p2_b_r) - 19'(p2_r_r);
      dv_nxt[0].hbase = 12'd1200;
    end else begin
      hx = 19'(p2_r_r) - 19'(p2_g_r);
      dv_nxt[0].hbase = 12'd2400;
    end
    hxmag = hx[18] ? 18'(-hx) : hx[17:0];
    dv_nxt[0].hrem = 28'(hxmag) * 28'd600;
    dv_nxt[0].hneg = hx[18];
    dv_nxt[0].hdiv = (df == '0) ? 18'd1 : df;
    dv_nxt[0].snum = {df, 12'b0};
    dv_nxt[0].sneg = mx[17];
    dv_nxt[0].sdiv = (mx == '0) ? 18'd1 : (mx[17] ? 18'(-mx) : mx[17:0]);
    dv_nxt[0].v    = mx;
  end

  // divider stages: saturation one bit each, hue over the first ten
  for (genvar j = 1; j <= S_DIV_STAGES; j++) begin : g_div
    logic [18:0] trial;
    logic        sge;
    div_stage_t  sat_nxt;
    always_comb begin
      sat_nxt = dv_r[j-1];
      trial = {dv_r[j-1].srem, dv_r[j-1].snum[S_DIV_STAGES-j]};
      sge   = (trial >= {1'b0, dv_r[j-1].sdiv});
      sat_nxt.sq[S_DIV_STAGES-j] = sge;
      sat_nxt.srem = sge ? 18'(trial - {1'b0, dv_r[j-1].sdiv}) : trial[17:0];
    end
    if (j <= H_DIV_STAGES) begin : g_hue
      localparam int HK = H_DIV_STAGES - j;
      logic [27:0] hsub;
      logic        hge;
      always_comb begin
        hsub = {10'b0, dv_r[j-1].hdiv} << HK;
        hge  = (dv_r[j-1].hrem >= hsub);
        dv_nxt[j]        = sat_nxt;
        dv_nxt[j].hq[HK] = hge;
        dv_nxt[j].hrem   = hge ? dv_r[j-1].hrem - hsub : dv_r[j-1].hrem;
      end
    end else begin : g_pass
      always_comb begin
        dv_nxt[j] = sat_nxt;
      end
    end
    always_ff @(posedge clk) begin
      dv_r[j] <= dv_nxt[j];
    end
  end

  always_ff @(posedge clk) begin
    dv_r[0] <= dv_nxt[0];
  end

  // stage 4: signed hue and saturation, add shift
  logic signed [14:0] p4_h_r;
  logic signed [30:0] p4_s_r;
  logic signed [17:0] p4_v_r;
  logic signed [14:0] hq_s;

  always_comb begin
    hq_s = $signed({5'b0, dv_r[S_DIV_STAGES].hq});
    if (dv_r[S_DIV_STAGES].hneg) begin
      hq_s = -hq_s;
    end
  end

  always_ff @(posedge clk) begin
    p4_h_r <= hq_s + $signed({3'b0, dv_r[S_DIV_STAGES].hbase}) + 15'(hue_shift_r);
    p4_s_r <= dv_r[S_DIV_STAGES].sneg ? -$signed({1'b0, dv_r[S_DIV_STAGES].sq})
                                      : $signed({1'b0, dv_r[S_DIV_STAGES].sq});
    p4_v_r <= dv_r[S_DIV_STAGES].v;
  end

  // stage 5: hue wrap, t = v * s
  logic signed [48:0] tfull;
  logic signed [14:0] hw;
  logic signed [31:0] p5_t_r;
  logic [11:0]        p5_h_r;
  logic signed [17:0] p5_v_r;

  always_comb begin
    tfull = p4_v_r * p4_s_r;
    hw = p4_h_r;
    if (hw < 0) begin
      hw = hw + 15'sd3600;
    end
    if (hw < 0) begin
      hw = hw + 15'sd3600;
    end
    if (hw >= 15'sd3600) begin
      hw = hw - 15'sd3600;
    end
  end

  always_ff @(posedge clk) begin
    p5_t_r <= tfull[31:0];
    p5_h_r <= hw[11:0];
    p5_v_r <= p4_v_r;
  end

  // stage 6: reciprocal product for t / 75, low level
  logic [31:0]        tneg_v;
  logic signed [31:0] tsh;
  logic [59:0]        p6_prod_r;
  logic               p6_tneg_r;
  logic signed [21:0] p6_lo_r;
  logic [11:0]        p6_h_r;
  logic signed [17:0] p6_v_r;

  always_comb begin
    tneg_v = -p5_t_r;
    tsh    = p5_t_r >>> 12;
  end

  always_ff @(posedge clk) begin
    p6_prod_r <= (p5_t_r[31] ? tneg_v[29:0] : p5_t_r[29:0]) * RECIP_75;
    p6_tneg_r <= p5_t_r[31];
    p6_lo_r   <= 22'(p5_v_r) - 22'(tsh);
    p6_h_r    <= p5_h_r;
    p6_v_r    <= p5_v_r;
  end

  // stage 7: q, sector, ramp distance
  logic signed [24:0] qv;
  hue_sector_t        sec;
  logic [11:0]        kd;
  logic signed [24:0] p7_q_r;
  logic [9:0]         p7_k_r;
  hue_sector_t        p7_sec_r;
  logic signed [21:0] p7_lo_r;
  logic signed [17:0] p7_v_r;

  always_comb begin
    qv = $signed({1'b0, p6_prod_r[59:RECIP_SHIFT]});
    if (p6_tneg_r) begin
      qv = -qv;
    end
    if (p6_h_r < 12'd600) begin
      sec = SEC_RY;
      kd  = 12'd600 - p6_h_r;
    end else if (p6_h_r < 12'd1200) begin
      sec = SEC_YG;
      kd  = p6_h_r - 12'd600;
    end else if (p6_h_r < 12'd1800) begin
      sec = SEC_GC;
      kd  = 12'd1800 - p6_h_r;
    end else if (p6_h_r < 12'd2400) begin
      sec = SEC_CB;
      kd  = p6_h_r - 12'd1800;
    end else if (p6_h_r < 12'd3000) begin
      sec = SEC_BM;
      kd  = 12'd3000 - p6_h_r;
    end else begin
      sec = SEC_MR;
      kd  = p6_h_r - 12'd3000;
    end
  end

  always_ff @(posedge clk) begin
    p7_q_r   <= qv;
    p7_k_r   <= kd[9:0];
    p7_sec_r <= sec;
    p7_lo_r  <= p6_lo_r;
    p7_v_r   <= p6_v_r;
  end

  // stage 8: ramp product
  logic signed [35:0] p8_qk_r;
  hue_sector_t        p8_sec_r;
  logic signed [21:0] p8_lo_r;
  logic signed [17:0] p8_v_r;

  always_ff @(posedge clk) begin
    p8_qk_r  <= p7_q_r * $signed({1'b0, p7_k_r});
    p8_sec_r <= p7_sec_r;
    p8_lo_r  <= p7_lo_r;
    p8_v_r   <= p7_v_r;
  end

  // stage 9: rgb from hsv
  logic signed [35:0] qksh;
  logic signed [21:0] vw, ramp;
  logic signed [21:0] r2, g2, b2;
  logic signed [21:0] p9_r_r, p9_g_r, p9_b_r;

  always_comb begin
    qksh = p8_qk_r >>> 15;
    vw   = 22'(p8_v_r);
    ramp = vw - 22'(qksh);
    case (p8_sec_r)
      SEC_RY: begin r2 = vw;      g2 = ramp;    b2 = p8_lo_r; end
      SEC_YG: begin r2 = ramp;    g2 = vw;      b2 = p8_lo_r; end
      SEC_GC: begin r2 = p8_lo_r; g2 = vw;      b2 = ramp;    end
      SEC_CB: begin r2 = p8_lo_r; g2 = ramp;    b2 = vw;      end
      SEC_BM: begin r2 = ramp;    g2 = p8_lo_r; b2 = vw;      end
      default: begin r2 = vw;     g2 = p8_lo_r; b2 = ramp;    end
    endcase
  end

  always_ff @(posedge clk) begin
    p9_r_r <= r2;
    p9_g_r <= g2;
    p9_b_r <= b2;
  end

  // stage 10: output matrix products
  logic signed [36:0] p10_yr_r, p10_yg_r, p10_yb_r;
  logic signed [36:0] p10_br_r, p10_bg_r, p10_bb_r;
  logic signed [36:0] p10_rr_r, p10_rg_r, p10_rb_r;

  always_ff @(posedge clk) begin
    p10_yr_r <= p9_r_r * K_Y_R;
    p10_yg_r <= p9_g_r * K_Y_G;
    p10_yb_r <= p9_b_r * K_Y_B;
    p10_br_r <= p9_r_r * K_CB_R;
    p10_bg_r <= p9_g_r * K_CB_G;
    p10_bb_r <= p9_b_r * K_CB_B;
    p10_rr_r <= p9_r_r * K_CR_R;
    p10_rg_r <= p9_g_r * K_CR_G;
    p10_rb_r <= p9_b_r * K_CR_B;
  end

  // stage 11: matrix sums
  logic signed [38:0] ys, cbs, crs;
  logic signed [38:0] ysh, cbsh, crsh;
  logic signed [25:0] p11_y_r, p11_cb_r, p11_cr_r;

  always_comb begin
    ys   = 39'(p10_yr_r) + 39'(p10_yg_r) + 39'(p10_yb_r);
    cbs  = 39'(p10_br_r) + 39'(p10_bg_r) + 39'(p10_bb_r);
    crs  = 39'(p10_rr_r) + 39'(p10_rg_r) + 39'(p10_rb_r);
    ysh  = ys >>> 14;
    cbsh = cbs >>> 14;
    crsh = crs >>> 14;
  end

  always_ff @(posedge clk) begin
    p11_y_r  <= ysh[25:0];
    p11_cb_r <= cbsh[25:0];
    p11_cr_r <= crsh[25:0];
  end

  // stage 12: gains
  logic signed [39:0] p12_y_r, p12_cb_r, p12_cr_r;

  always_ff @(posedge clk) begin
    p12_y_r  <= p11_y_r * $signed({1'b0, luma_gain_r});
    p12_cb_r <= p11_cb_r * $signed({1'b0, chroma_gain_r});
    p12_cr_r <= p11_cr_r * $signed({1'b0, chroma_gain_r});
  end

  // stage 13: offset and 16-bit truncation
  logic signed [39:0] ygs, cbgs, crgs;
  logic signed [32:0] yoff;
  logic signed [15:0] p13_y_r, p13_cb_r, p13_cr_r;

  always_comb begin
    ygs  = p12_y_r >>> 8;
    cbgs = p12_cb_r >>> 8;
    crgs = p12_cr_r >>> 8;
    yoff = 33'(ygs) + 33'(bright_r);
  end

  always_ff @(posedge clk) begin
    p13_y_r  <= yoff[15:0];
    p13_cb_r <= cbgs[15:0];
    p13_cr_r <= crgs[15:0];
  end

  // stage 14: clamp decision and fade products
  clamp_sel_t         csel;
  logic signed [16:0] fade;
  logic signed [13:0] fmul;
  clamp_sel_t         p14_sel_r;
  logic               p14_fpos_r;
  logic signed [29:0] p14_pcb_r, p14_pcr_r;
  logic signed [15:0] p14_y_r, p14_cb_r, p14_cr_r;

  always_comb begin
    if (clamp_r && p13_y_r < 0) begin
      csel = CLP_LOW;
      fade = 17'(p13_y_r) + FADE_LOW;
    end else if (clamp_r && 17'(p13_y_r) > LUMA_MAX) begin
      csel = CLP_HIGH;
      fade = FADE_TOP - 17'(p13_y_r);
    end else begin
      csel = CLP_NONE;
      fade = '0;
    end
    fmul = $signed({1'b0, fade[12:0]});
  end

  always_ff @(posedge clk) begin
    p14_sel_r  <= csel;
    p14_fpos_r <= (fade > 0);
    p14_pcb_r  <= fmul * p13_cb_r;
    p14_pcr_r  <= fmul * p13_cr_r;
    p14_y_r    <= p13_y_r;
    p14_cb_r   <= p13_cb_r;
    p14_cr_r   <= p13_cr_r;
  end

  // stage 15: result register
  logic signed [29:0] fcb_lo, fcr_lo, fcb_hi, fcr_hi;
  logic signed [15:0] y_nxt, cb_nxt, cr_nxt;
  logic signed [15:0] out_y_r, out_cb_r, out_cr_r;

  always_comb begin
    fcb_lo = p14_pcb_r >>> 10;
    fcr_lo = p14_pcr_r >>> 10;
    fcb_hi = p14_pcb_r >>> 12;
    fcr_hi = p14_pcr_r >>> 12;
    case (p14_sel_r)
      CLP_LOW: begin
        y_nxt  = '0;
        cb_nxt = p14_fpos_r ? fcb_lo[15:0] : '0;
        cr_nxt = p14_fpos_r ? fcr_lo[15:0] : '0;
      end
      CLP_HIGH: begin
        y_nxt  = LUMA_MAX[15:0];
        cb_nxt = p14_fpos_r ? fcb_hi[15:0] : '0;
        cr_nxt = p14_fpos_r ? fcr_hi[15:0] : '0;
      end
      default: begin
        y_nxt  = p14_y_r;
        cb_nxt = p14_cb_r;
        cr_nxt = p14_cr_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_y_r  <= y_nxt;
    out_cb_r <= cb_nxt;
    out_cr_r <= cr_nxt;
  end

  assign out_valid  = vld_r[LATENCY-1];
  assign out_y_out  = out_y_r;
  assign out_cb_out = out_cb_r;
  assign out_cr_out = out_cr_r;

endmodule

### rtl/core/yhra_checker.sv
module yhra_checker
  import yhra_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // every result strobe comes from a transaction a fixed latency earlier
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result strobe without matching transaction");

  // reset flushes the pipeline
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // fully pipelined, never refuses a transaction
  a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

endmodule

bind ycbcr_hue_rotate_adjust yhra_checker u_yhra_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
